>>> rtl/core/iwrq_pkg.sv
// Shared types, codes and defaults of the instruction window retire queue.
package iwrq_pkg;

    // Default sizes of the window
    localparam int DEF_WINDOW_DEPTH = 128;
    localparam int DEF_ADDR_BITS    = 48;

    // Field widths fixed by the request and result formats
    localparam int OP_W      = 2;
    localparam int CFG_W     = 4;
    localparam int RETIRED_W = 4;
    localparam int OCC_W     = 8;
    localparam int M_DATA_W  = 16;

    // Retire port limit and reset value of the retire width register
    localparam logic [CFG_W-1:0] MAX_RETIRE         = CFG_W'(8);
    localparam logic [CFG_W-1:0] RETIRE_WIDTH_RESET = CFG_W'(4);

    // Request kinds carried on the slave tuser
    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_RETIRE   = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // capture the request and prime the counters
        logic insert;     // append an entry at the head if there is room
        logic ret_step;   // retire the tail entry
        logic scan_run;   // advance the address match scan
        logic out_load;   // load the result register
    } iwrq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ret_ok;     // tail entry may retire in this tick
        logic scan_busy;  // scan still has reads to issue or a read pending
    } iwrq_status_t;

endpackage

>>> rtl/core/instruction_window_retire_queue.sv
// Top level of the instruction window retire queue.
//
// Slave stream: one request per handshake. s_tuser carries the kind (insert,
// retire tick, complete address); s_tdata carries ready_req and the address.
// Master stream: one result per request with accepted, retired count,
// occupancy after the request and the full flag.
// cfg_wr_en/cfg_wr_data write the retire width; write it only while idle.
// An insert appends at the head if there is room; a retire tick retires tail
// entries while the tail is ready and the retire limit is not reached; a
// complete scans the address RAM one entry a cycle, comparing each read as it
// returns, and sets the ready bit of every match; an unused kind only reports.
// One request is worked at a time; the next is taken the cycle after the
// result is loaded into the output register, which holds it while the
// receiver stalls and lets the next request be accepted and worked meanwhile.
// Reset empties the window, clears all ready bits and sets the retire width
// to four; the address RAM is not cleared and needs no clearing pass.
module instruction_window_retire_queue
    import iwrq_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((ADDR_BITS+8)/8)*8-1:0] s_tdata,  // ready_req, addr, zero pad
    input  logic [OP_W-1:0]                s_tuser,  // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_DATA_W-1:0]            m_tdata,  // accepted, retired_count,
                                                     // occupancy, full_res, zero pad
    input  logic                           cfg_wr_en,
    input  logic [CFG_W-1:0]               cfg_wr_data
);

    iwrq_cmd_t    cmd;
    iwrq_status_t status;

    iwrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    iwrq_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADDR_BITS    (ADDR_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata)
    );

endmodule

>>> rtl/core/iwrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iwrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word and register one read a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/iwrq_datapath.sv
// Window datapath: pointers, ready bits, address store, scan and result register.
module iwrq_datapath
    import iwrq_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  iwrq_cmd_t                         cmd,
    output iwrq_status_t                      status,
    input  logic [((ADDR_BITS+8)/8)*8-1:0]    s_tdata,
    input  logic                              cfg_wr_en,
    input  logic [CFG_W-1:0]                  cfg_wr_data,
    output logic [M_DATA_W-1:0]               m_tdata
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        next_slot = (i == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Request payload
    logic                 rdy_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    // Window state
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [WINDOW_DEPTH-1:0] ready_reg, ready_next;
    logic [CFG_W-1:0]        rw_reg;

    // Per-request working state
    logic [RETIRED_W-1:0] ret_cnt_reg, ret_cnt_next;
    logic                 acc_reg, acc_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     scan_k_reg, scan_k_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg;

    // Result register
    logic                 out_acc_reg;
    logic [RETIRED_W-1:0] out_ret_reg;
    logic [OCC_W-1:0]     out_occ_reg;
    logic                 out_full_reg;

    logic                     full;
    logic [CFG_W-1:0]         limit;
    logic                     scan_issue;
    logic                     do_insert;
    logic                     match;
    logic [ADDR_BITS-1:0]     ram_rdata;
    logic [CNT_W+OCC_W-1:0]   occ_wide;

    assign full       = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign limit      = (rw_reg > MAX_RETIRE) ? MAX_RETIRE : rw_reg;
    assign do_insert  = cmd.insert && !full;
    assign scan_issue = cmd.scan_run && (scan_k_reg < count_reg);
    assign match      = cmd.scan_run && pend_reg && (ram_rdata == addr_reg);

    assign status.ret_ok    = (count_reg != '0) && (ret_cnt_reg < limit) && ready_reg[tail_reg];
    assign status.scan_busy = (scan_k_reg < count_reg) || pend_reg;

    // Address store, written by inserts, read by the match scan
    iwrq_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_addr_ram (
        .aclk  (aclk),
        .we    (do_insert),
        .waddr (head_reg),
        .wdata (addr_reg),
        .re    (scan_issue),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // Work out next window and working state
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        ready_next    = ready_reg;
        ret_cnt_next  = ret_cnt_reg;
        acc_next      = acc_reg;
        scan_idx_next = scan_idx_reg;
        scan_k_next   = scan_k_reg;
        pend_next     = pend_reg;
        if (cmd.latch) begin
            ret_cnt_next  = '0;
            acc_next      = 1'b0;
            scan_idx_next = tail_reg;
            scan_k_next   = '0;
            pend_next     = 1'b0;
        end
        if (do_insert) begin
            ready_next[head_reg] = rdy_reg;
            head_next            = next_slot(head_reg);
            count_next           = count_reg + 1'b1;
            acc_next             = 1'b1;
        end
        if (cmd.ret_step) begin
            tail_next    = next_slot(tail_reg);
            count_next   = count_reg - 1'b1;
            ret_cnt_next = ret_cnt_reg + 1'b1;
        end
        if (cmd.scan_run) begin
            pend_next = scan_issue;
            if (scan_issue) begin
                scan_idx_next = next_slot(scan_idx_reg);
                scan_k_next   = scan_k_reg + 1'b1;
            end
        end
        if (match) begin
            ready_next[pend_idx_reg] = 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            ready_reg    <= '0;
            rw_reg       <= RETIRE_WIDTH_RESET;
            ret_cnt_reg  <= '0;
            acc_reg      <= 1'b0;
            scan_idx_reg <= '0;
            scan_k_reg   <= '0;
            pend_reg     <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            ready_reg    <= ready_next;
            ret_cnt_reg  <= ret_cnt_next;
            acc_reg      <= acc_next;
            scan_idx_reg <= scan_idx_next;
            scan_k_reg   <= scan_k_next;
            pend_reg     <= pend_next;
            if (cfg_wr_en) begin
                rw_reg <= cfg_wr_data;
            end
        end
    end

    // Capture request payload and the index of the read in flight
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            rdy_reg  <= s_tdata[0];
            addr_reg <= s_tdata[ADDR_BITS:1];
        end
        if (scan_issue) begin
            pend_idx_reg <= scan_idx_reg;
        end
    end

    // Load the result register
    assign occ_wide = {{OCC_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_acc_reg  <= acc_reg;
            out_ret_reg  <= ret_cnt_reg;
            out_occ_reg  <= occ_wide[OCC_W-1:0];
            out_full_reg <= full;
        end
    end

    assign m_tdata = {2'b00, out_full_reg, out_occ_reg, out_ret_reg, out_acc_reg};

endmodule

>>> rtl/core/iwrq_ctrl.sv
// Request sequencer: accepts a request, steps its work and hands over the result.
module iwrq_ctrl
    import iwrq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [OP_W-1:0] s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output iwrq_cmd_t    cmd,
    input  iwrq_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_RETIRE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    op_t    op;

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Choose next state and commands
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    case (op)
                        OP_INSERT:   state_next = ST_INSERT;
                        OP_RETIRE:   state_next = ST_RETIRE;
                        OP_COMPLETE: state_next = ST_SCAN;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_FINISH;
            end
            ST_RETIRE: begin
                if (status.ret_ok) begin
                    cmd.ret_step = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (!status.scan_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
